/* sv/hpe_pkg.sv */
// Package for the HPACK Huffman encoder: payload structs, constants and the
// static code table (RFC 7541 Appendix B). No dependencies.
`default_nettype none
package hpe_pkg;

    localparam int unsigned CODE_W = 30;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned ACC_W  = CODE_W + 7;
    localparam int unsigned CNT_W  = 6;

    typedef struct packed {
        logic [7:0] symbol;
        logic       is_last;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_string;
    } t_out_req;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              is_last;
    } t_code_req;

    typedef logic [CODE_W-1:0] t_code;
    typedef logic [LEN_W-1:0]  t_len;

    localparam t_code CODE_VAL [256] = '{
        30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,
        30'hfffffe7,30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,
        30'hfffffeb,30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,
        30'hffffff2,30'h3ffffffe,30'hffffff3,30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,
        30'hffffff8,30'hffffff9,30'hffffffa,30'hffffffb,
        30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
        30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
        30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
        30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
        30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
        30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
        30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
        30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
        30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
        30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
        30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
        30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
        30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
        30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
        30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
        30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
        30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
        30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
        30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
        30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
        30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
        30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
        30'h1ffffed,
        30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,
        30'hfffff2,
        30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,
        30'h7ffffe5,
        30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
        30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,
        30'h7ffff4,
        30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
        30'h7ffffea,
        30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,
        30'h3ffffee
    };

    localparam t_len CODE_LEN [256] = '{
        5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,
        5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
        5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,
        5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
        5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,
        5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
        5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
        5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
        5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,
        5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
        5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,
        5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
        5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,
        5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
        5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,
        5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
        5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,
        5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
        5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,
        5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
        5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,
        5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
        5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,
        5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
        5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,
        5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
        5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,
        5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26
    };

endpackage
`default_nettype wire

/* sv/hpack_huffman_encoder_top.sv */
// HPACK static Huffman string encoder, top level. Depends on hpe_pkg,
// hpe_front and hpe_back.
// One octet per request goes in; encoded bytes come out MSB first, at most
// one per cycle, with end_of_string on the last byte of each string (tail
// padded with ones). The back end emits one byte per cycle when the output
// register is free, and takes the next code in the same cycle as the byte
// that leaves fewer than 8 bits pending, so an octet that yields several
// bytes (up to 5, counting the pad byte) holds the input until those bytes
// have left. An accepted octet goes through a FIFO entry and the bit
// accumulator before its first byte reaches the output register. A small
// FIFO between lookup and emitter absorbs short bursts of long codes.
`default_nettype none
module hpack_huffman_encoder_top
    import hpe_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH_LOG2 = 1
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_in_req i_data,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_out_req     o_data
);
    logic      q_valid, q_ready;
    t_code_req q_data;

    hpe_front #(.DEPTH_LOG2(FIFO_DEPTH_LOG2)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    hpe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_data  (q_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule
`default_nettype wire

/* sv/hpe_front.sv */
// Front end: accepts octets, looks up their Huffman code and length, and
// pushes code requests into a small FIFO. Depends on hpe_pkg.
`default_nettype none
module hpe_front
    import hpe_pkg::*;
#(
    parameter int unsigned DEPTH_LOG2 = 1
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_req   i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_code_req      o_data
);
    localparam int unsigned DEPTH = 1 << DEPTH_LOG2;

    t_code_req r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [DEPTH_LOG2:0]   r_cnt, n_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (DEPTH_LOG2+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + (DEPTH_LOG2+1)'(push) - (DEPTH_LOG2+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{code:    CODE_VAL[i_data.symbol],
                             len:     CODE_LEN[i_data.symbol],
                             is_last: i_data.is_last};
        end
    end
endmodule
`default_nettype wire

/* sv/hpe_back.sv */
// Back end: merges codes into the bit accumulator and emits one byte per
// cycle, while the output is free, into an output register, padding the
// string's tail with ones. Depends on hpe_pkg.
`default_nettype none
module hpe_back
    import hpe_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_code_req i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_req       o_data
);
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_last, n_last;
    logic             r_ovalid, n_ovalid;
    t_out_req         r_out, n_out;
    logic             out_free, take, emit;
    logic [ACC_W-1:0] byte_sh;
    logic [7:0]       cur_byte;
    logic [CNT_W-1:0] rem, cnt_post;
    logic             last_done, last_post;

    assign out_free  = !r_ovalid || i_ready;
    assign emit      = out_free && ((r_cnt >= CNT_W'(8)) || (r_last && r_cnt != '0));
    assign rem       = (r_cnt >= CNT_W'(8)) ? r_cnt - CNT_W'(8) : '0;
    assign last_done = emit && r_last && (rem == '0);
    assign cnt_post  = emit ? rem : r_cnt;
    assign last_post = r_last && !last_done;
    // take a code once this cycle's byte leaves fewer than 8 bits and no tail
    assign o_ready   = (cnt_post < CNT_W'(8)) && !last_post;
    assign take      = i_valid && o_ready;
    assign o_valid   = r_ovalid;
    assign o_data    = r_out;

    always_comb begin
        byte_sh  = (r_cnt >= CNT_W'(8)) ? (r_acc >> rem)
                                        : ((r_acc << (CNT_W'(8) - r_cnt))
                                           | ACC_W'(8'hFF >> r_cnt[2:0]));
        cur_byte = byte_sh[7:0];

        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_last   = r_last;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;

        if (emit) begin
            n_ovalid            = 1'b1;
            n_out.out_byte      = cur_byte;
            n_out.end_of_string = last_done;
            n_cnt               = rem;
            if (last_done) begin
                n_last = 1'b0;
                n_acc  = '0;
            end
        end
        if (take) begin
            n_acc  = (ACC_W'(n_acc[6:0]) << i_data.len) | ACC_W'(i_data.code);
            n_cnt  = n_cnt + CNT_W'(i_data.len);
            n_last = i_data.is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_last   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end
endmodule
`default_nettype wire
